// ===== rtl/battery_gauge_charge_trend_defines.svh =====
// ----------------------------------------------------------------------------
// Battery gauge assertion macros
// Shared concurrent-check shorthands, clocked on clk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef BATTERY_GAUGE_CHARGE_TREND_DEFINES_SVH
`define BATTERY_GAUGE_CHARGE_TREND_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define BGCT_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("battery gauge check failed");

// consequent must hold in the cycle after the antecedent
`define BGCT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("battery gauge check failed");

`endif

// ===== rtl/bgct_pkg.sv =====
// ----------------------------------------------------------------------------
// Battery gauge package
// Payload types and fixed constants shared by the gauge pipeline.
// ----------------------------------------------------------------------------
package bgct_pkg;

	localparam logic [12:0] VBAT_MIN_MV = 13'd3000;
	localparam logic [12:0] VBAT_MAX_MV = 13'd4350;
	localparam logic [12:0] PCT_LOW_MV  = 13'd3300;
	localparam logic [12:0] PCT_MID_MV  = 13'd3700;
	localparam logic [12:0] PCT_HIGH_MV = 13'd4200;
	localparam logic [6:0]  PCT_FULL    = 7'd100;
	localparam logic [6:0]  PCT_HALF    = 7'd50;

	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 48;

	typedef enum logic [1:0] {
		REG_PRESENT_MIN = 2'd0,
		REG_DIVIDER     = 2'd1,
		REG_WINDOW      = 2'd2,
		REG_RISE        = 2'd3
	} reg_idx_t;

	// members listed from the top bit down, so the first field sits highest
	typedef struct packed {
		logic [31:0] now_ms;
		logic        usb_sense;
		logic [11:0] adc_mv;
		logic [11:0] adc_raw;
	} in_t;

	typedef struct packed {
		logic        charging;
		logic [6:0]  charge_pct;
		logic [12:0] vbat_mv;
		logic [11:0] pin_mv_avg;
		logic [11:0] raw_avg;
		logic        usb_present;
		logic        batt_present;
	} result_t;

	localparam int IN_W  = $bits(in_t);
	localparam int RES_W = $bits(result_t);

	typedef struct packed {
		logic [31:0] now_ms;
		logic        usb;
	} tag_t;

	typedef struct packed {
		logic [31:0] now_ms;
		logic [12:0] vbat_mv;
		logic [11:0] mv_avg;
		logic [11:0] raw_avg;
		logic        usb;
		logic        present;
	} scaled_t;

	typedef struct packed {
		logic [11:0] present_min_mv;
		logic [11:0] divider_q8;
		logic [31:0] trend_period_ms;
		logic [12:0] charge_rise_mv;
	} cfg_t;

endpackage

// ===== rtl/bgct_accum.sv =====
// ----------------------------------------------------------------------------
// Battery gauge sample accumulator
// Sums samples of one group and hands the group sums to the next stage.
// ----------------------------------------------------------------------------
module bgct_accum #(
	parameter int GROUP_SIZE = 8,
	parameter int ACC_W      = 15
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  bgct_pkg::in_t      in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [ACC_W-1:0]   raw_sum,
	output logic [ACC_W-1:0]   mv_sum,
	output bgct_pkg::tag_t     tag
);

	localparam int CNT_W = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;

	logic [CNT_W-1:0] cnt_q;
	logic [ACC_W-1:0] raw_acc_q, mv_acc_q;
	logic [ACC_W-1:0] raw_next, mv_next;
	logic [ACC_W-1:0] raw_s1, mv_s1;
	bgct_pkg::tag_t   tag_s1;
	logic             v_s1;
	logic             last, take;

	assign last     = (cnt_q == CNT_W'(GROUP_SIZE - 1));
	// only a group-closing sample needs room downstream
	assign in_ready = !last || !v_s1 || out_ready;
	assign take     = in_valid && in_ready;
	assign raw_next = raw_acc_q + ACC_W'(in_data.adc_raw);
	assign mv_next  = mv_acc_q + ACC_W'(in_data.adc_mv);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			raw_acc_q <= '0;
			mv_acc_q  <= '0;
			v_s1      <= 1'b0;
		end else begin
			if (take && last) begin
				cnt_q     <= '0;
				raw_acc_q <= '0;
				mv_acc_q  <= '0;
			end else if (take) begin
				cnt_q     <= cnt_q + 1'b1;
				raw_acc_q <= raw_next;
				mv_acc_q  <= mv_next;
			end
			if (take && last) begin
				v_s1 <= 1'b1;
			end else if (out_ready) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && last) begin
			raw_s1        <= raw_next;
			mv_s1         <= mv_next;
			tag_s1.usb    <= in_data.usb_sense;
			tag_s1.now_ms <= in_data.now_ms;
		end
	end

	assign out_valid = v_s1;
	assign raw_sum   = raw_s1;
	assign mv_sum    = mv_s1;
	assign tag       = tag_s1;

endmodule

// ===== rtl/bgct_scale.sv =====
// ----------------------------------------------------------------------------
// Battery gauge averaging and scaling
// Averages the group sums, applies the divider ratio and the clamp, and checks presence.
// ----------------------------------------------------------------------------
module bgct_scale #(
	parameter int GROUP_SIZE = 8,
	parameter int ACC_W      = 15
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [ACC_W-1:0]    raw_sum,
	input  logic [ACC_W-1:0]    mv_sum,
	input  bgct_pkg::tag_t      tag,
	input  bgct_pkg::cfg_t      cfg,
	output logic                out_valid,
	input  logic                out_ready,
	output bgct_pkg::scaled_t   out_data
);

	// floor(x / GROUP_SIZE) as (x * RECIP) >> SH, exact for every ACC_W-bit x
	localparam int SH     = ACC_W + $clog2(GROUP_SIZE);
	localparam int M_W    = ACC_W + 1;
	localparam int PROD_W = ACC_W + M_W;
	localparam logic [M_W-1:0] RECIP = M_W'(((2 ** SH) + GROUP_SIZE - 1) / GROUP_SIZE);

	logic [PROD_W-1:0] raw_prod, mv_prod;
	logic [11:0]       raw_avg_s2, mv_avg_s2;
	bgct_pkg::tag_t    tag_s2;
	logic              v_s2, v_s3;
	logic              ready_s3, ready_s2;
	logic [23:0]       vbat_prod;
	logic [15:0]       vbat_full;
	logic [12:0]       vbat_clamped;
	bgct_pkg::scaled_t res_s3;

	assign ready_s3 = !v_s3 || out_ready;
	assign ready_s2 = !v_s2 || ready_s3;
	assign in_ready = ready_s2;

	assign raw_prod = PROD_W'(raw_sum) * PROD_W'(RECIP);
	assign mv_prod  = PROD_W'(mv_sum) * PROD_W'(RECIP);

	assign vbat_prod = 24'(mv_avg_s2) * 24'(cfg.divider_q8);
	assign vbat_full = vbat_prod[23:8];

	always_comb begin
		if (vbat_full < 16'(bgct_pkg::VBAT_MIN_MV)) begin
			vbat_clamped = bgct_pkg::VBAT_MIN_MV;
		end else if (vbat_full > 16'(bgct_pkg::VBAT_MAX_MV)) begin
			vbat_clamped = bgct_pkg::VBAT_MAX_MV;
		end else begin
			vbat_clamped = vbat_full[12:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (ready_s2) begin
				v_s2 <= in_valid;
			end
			if (ready_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && in_valid) begin
			raw_avg_s2 <= raw_prod[SH +: 12];
			mv_avg_s2  <= mv_prod[SH +: 12];
			tag_s2     <= tag;
		end
		if (ready_s3 && v_s2) begin
			res_s3.now_ms  <= tag_s2.now_ms;
			res_s3.usb     <= tag_s2.usb;
			res_s3.raw_avg <= raw_avg_s2;
			res_s3.mv_avg  <= mv_avg_s2;
			res_s3.present <= (mv_avg_s2 >= cfg.present_min_mv);
			res_s3.vbat_mv <= vbat_clamped;
		end
	end

	assign out_valid = v_s3;
	assign out_data  = res_s3;

endmodule

// ===== rtl/bgct_trend.sv =====
// ----------------------------------------------------------------------------
// Battery gauge trend and percent stage
// Keeps the charging trend window, maps millivolts to percent, and holds
// the result register toward the output channel.
// ----------------------------------------------------------------------------
module bgct_trend (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  bgct_pkg::scaled_t   in_data,
	input  bgct_pkg::cfg_t      cfg,
	output logic                out_valid,
	input  logic                out_ready,
	output bgct_pkg::result_t   out_data
);

	// floor(x / 10) as (x * 205) >> 11, exact for x below 1029
	localparam logic [16:0] DIV10_MUL   = 17'd205;
	localparam int          DIV10_SHIFT = 11;

	logic              armed_q, flag_q;
	logic [31:0]       start_time_q;
	logic [12:0]       start_mv_q;
	logic              v_s4;
	bgct_pkg::result_t res_s4;
	logic              load;

	logic [12:0]        v, lo_diff;
	logic [8:0]         hi_diff;
	logic [16:0]        hi_prod;
	logic [6:0]         pct;
	logic [31:0]        elapsed;
	logic signed [13:0] dv;
	logic               window_hit, rise_ok, flag_next;

	assign in_ready = !v_s4 || out_ready;
	assign load     = in_valid && in_ready;

	assign v       = in_data.vbat_mv;
	assign lo_diff = v - bgct_pkg::PCT_LOW_MV;
	assign hi_diff = 9'(v - bgct_pkg::PCT_MID_MV);
	assign hi_prod = 17'(hi_diff) * DIV10_MUL;

	always_comb begin
		if (v >= bgct_pkg::PCT_HIGH_MV) begin
			pct = bgct_pkg::PCT_FULL;
		end else if (v <= bgct_pkg::PCT_LOW_MV) begin
			pct = '0;
		end else if (v < bgct_pkg::PCT_MID_MV) begin
			// 50 percent over 400 mV is one percent per 8 mV
			pct = 7'(lo_diff >> 3);
		end else begin
			pct = bgct_pkg::PCT_HALF + 7'(hi_prod >> DIV10_SHIFT);
		end
	end

	assign elapsed    = in_data.now_ms - start_time_q;
	assign window_hit = (elapsed >= cfg.trend_period_ms);
	assign dv         = $signed({1'b0, v}) - $signed({1'b0, start_mv_q});
	assign rise_ok    = (dv >= $signed({1'b0, cfg.charge_rise_mv}));

	always_comb begin
		if (!in_data.present || !armed_q) begin
			flag_next = 1'b0;
		end else if (window_hit) begin
			flag_next = rise_ok;
		end else begin
			flag_next = flag_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q      <= 1'b0;
			flag_q       <= 1'b0;
			start_time_q <= '0;
			start_mv_q   <= '0;
			v_s4         <= 1'b0;
		end else begin
			if (load) begin
				flag_q  <= flag_next;
				armed_q <= 1'b1;
				if (!in_data.present) begin
					// restart the window from zero millivolts
					start_time_q <= in_data.now_ms;
					start_mv_q   <= '0;
				end else if (!armed_q || window_hit) begin
					start_time_q <= in_data.now_ms;
					start_mv_q   <= v;
				end
			end
			if (in_ready) begin
				v_s4 <= in_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s4.batt_present <= in_data.present;
			res_s4.usb_present  <= in_data.usb;
			res_s4.raw_avg      <= in_data.raw_avg;
			res_s4.pin_mv_avg   <= in_data.mv_avg;
			res_s4.vbat_mv      <= in_data.present ? v : '0;
			res_s4.charge_pct   <= in_data.present ? pct : '0;
			res_s4.charging     <= flag_next;
		end
	end

	assign out_valid = v_s4;
	assign out_data  = res_s4;

endmodule

// ===== rtl/battery_gauge_charge_trend.sv =====
// ----------------------------------------------------------------------------
// Battery gauge with charge trend
// Averages groups of converter samples into battery millivolts, charge
// percent and a charging flag.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            content
//  s_*       in         s_tvalid/s_tready    one converter sample
//  m_*       out        m_tvalid/m_tready    one gauge result per group
//  cfg_*     in         cfg_we               register write, no read-back
//
// One sample is taken every cycle while s_tready is high; a group of GROUP_SIZE samples
// yields one result once its last sample has passed the sum, average, scale and trend registers.
// Stalls on m_* back up through the result, scale, average and sum registers;
// s_tready drops only for a group-closing sample while all of them are full.
// Reset clears the sums, the trend window and the pipeline, and loads the
// register defaults.
// ----------------------------------------------------------------------------
module battery_gauge_charge_trend #(
	parameter int GROUP_SIZE = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// adc_raw[11:0], adc_mv[23:12], usb_sense[24], now_ms[56:25], zero fill
	input  logic [bgct_pkg::IN_DATA_W-1:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// batt_present[0], usb_present[1], raw_avg[13:2], pin_mv_avg[25:14],
	// vbat_mv[38:26], charge_pct[45:39], charging[46], zero fill
	output logic [47:0] m_tdata,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);

	localparam int ACC_W = 12 + $clog2(GROUP_SIZE);

	bgct_pkg::cfg_t    cfg_q;
	bgct_pkg::in_t     in_data;
	bgct_pkg::tag_t    tag_s1;
	bgct_pkg::scaled_t scaled;
	bgct_pkg::result_t result;
	logic [ACC_W-1:0]  raw_sum, mv_sum;
	logic              v1, r1, v3, r3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.present_min_mv  <= 12'd500;
			cfg_q.divider_q8      <= 12'd512;
			cfg_q.trend_period_ms <= 32'd60000;
			cfg_q.charge_rise_mv  <= 13'd20;
		end else if (cfg_we) begin
			case (bgct_pkg::reg_idx_t'(cfg_index))
				bgct_pkg::REG_PRESENT_MIN: cfg_q.present_min_mv  <= cfg_wdata[11:0];
				bgct_pkg::REG_DIVIDER:     cfg_q.divider_q8      <= cfg_wdata[11:0];
				bgct_pkg::REG_WINDOW:      cfg_q.trend_period_ms <= cfg_wdata;
				bgct_pkg::REG_RISE:        cfg_q.charge_rise_mv  <= cfg_wdata[12:0];
				default: ;
			endcase
		end
	end

	assign in_data = bgct_pkg::in_t'(s_tdata[bgct_pkg::IN_W-1:0]);

	bgct_accum #(
		.GROUP_SIZE(GROUP_SIZE),
		.ACC_W     (ACC_W)
	) u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_data  (in_data),
		.out_valid(v1),
		.out_ready(r1),
		.raw_sum  (raw_sum),
		.mv_sum   (mv_sum),
		.tag      (tag_s1)
	);

	bgct_scale #(
		.GROUP_SIZE(GROUP_SIZE),
		.ACC_W     (ACC_W)
	) u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v1),
		.in_ready (r1),
		.raw_sum  (raw_sum),
		.mv_sum   (mv_sum),
		.tag      (tag_s1),
		.cfg      (cfg_q),
		.out_valid(v3),
		.out_ready(r3),
		.out_data (scaled)
	);

	bgct_trend u_trend (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v3),
		.in_ready (r3),
		.in_data  (scaled),
		.cfg      (cfg_q),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data (result)
	);

	assign m_tdata = {{(bgct_pkg::OUT_DATA_W - bgct_pkg::RES_W){1'b0}}, result};

endmodule

// ===== rtl/bgct_checker.sv =====
// ----------------------------------------------------------------------------
// Battery gauge port checker
// Watches the result channel for held transactions and consistent fields.
// ----------------------------------------------------------------------------
`include "battery_gauge_charge_trend_defines.svh"

module bgct_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata
);

	bgct_pkg::result_t r;

	assign r = bgct_pkg::result_t'(m_tdata[bgct_pkg::RES_W-1:0]);

	// a stalled transaction stays put
	`BGCT_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// absent battery zeroes the derived fields
	`BGCT_ASSERT_SAME(a_absent_zero, m_tvalid && !r.batt_present,
		r.vbat_mv == '0 && r.charge_pct == '0 && !r.charging)

	// present battery voltage lies inside the clamp
	`BGCT_ASSERT_SAME(a_clamp, m_tvalid && r.batt_present,
		r.vbat_mv >= bgct_pkg::VBAT_MIN_MV && r.vbat_mv <= bgct_pkg::VBAT_MAX_MV)

	// full voltage reads full charge
	`BGCT_ASSERT_SAME(a_full, m_tvalid && r.batt_present && r.vbat_mv >= bgct_pkg::PCT_HIGH_MV,
		r.charge_pct == bgct_pkg::PCT_FULL)

endmodule

bind battery_gauge_charge_trend bgct_checker u_bgct_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

// ===== dv/battery_gauge_charge_trend_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Battery gauge with charge trend - testbench
// Streams converter samples into the gauge in groups and predicts each
// gauge reading in parallel: averages, presence, clamped battery millivolts,
// charge percent and the windowed charging verdict. Readings are checked in
// order against the predicted ones while both stream sides stall at random
// and the registers are moved through default, extreme and random settings.
// ----------------------------------------------------------------------------
module battery_gauge_charge_trend_tb;

	localparam int SAMPLES_PER_GROUP = 8;
	localparam int CYCLE_LIMIT       = 300000;
	localparam int SETTLE_CYCLES     = 12;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [47:0] m_tdata;
	logic        cfg_we    = 1'b0;
	logic [1:0]  cfg_index = bgct_pkg::REG_PRESENT_MIN;
	logic [31:0] cfg_wdata = '0;

	battery_gauge_charge_trend #(
		.GROUP_SIZE(SAMPLES_PER_GROUP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	bgct_pkg::in_t     pending_samples[$];
	bgct_pkg::result_t expected_readings[$];
	logic        idling_on = 1'b1;
	int          src_hold  = 0;
	int          sink_hold = 0;
	logic [31:0] stamp_ms  = '0;

	// gauge state as the block should hold it
	bgct_pkg::cfg_t cfg_shadow = {12'd500, 12'd512, 32'd60000, 13'd20};
	logic [14:0] sum_raw     = '0;
	logic [14:0] sum_mv      = '0;
	int          fill_cnt    = 0;
	logic        window_open = 1'b0;
	logic [31:0] window_t0   = '0;
	logic [12:0] window_mv0  = '0;
	logic        chg_latched = 1'b0;

	int accepted_samples = 0;
	int checked_readings = 0;
	int absent_seen      = 0;
	int charging_seen    = 0;
	int fail_count       = 0;
	int cycle_cnt        = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin : watchdog
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("timeout after %0d cycles, %0d readings outstanding", cycle_cnt,
			expected_readings.size());
		$display("Simulation FAILED");
		$finish;
	end

	// sample source: one transaction per item, random hold-off bursts between items
	always @(posedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || s_tready) begin
				if (src_hold > 0) begin
					src_hold <= src_hold - 1;
					s_tvalid <= 1'b0;
				end else if (pending_samples.size() != 0) begin
					s_tdata  <= {{(64 - bgct_pkg::IN_W){1'b0}}, pending_samples.pop_front()};
					s_tvalid <= 1'b1;
					if (idling_on && $urandom_range(0, 9) == 0)
						src_hold <= $urandom_range(1, 11);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// reading sink with random stall bursts
	always @(posedge clk) begin
		if (arst_n) begin
			if (sink_hold > 0) begin
				sink_hold <= sink_hold - 1;
				m_tready  <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (idling_on && $urandom_range(0, 7) == 0)
					sink_hold <= $urandom_range(1, 11);
			end
		end
	end

	always @(posedge clk) begin : monitor
		bgct_pkg::in_t     smp;
		bgct_pkg::result_t want;
		bgct_pkg::result_t got;
		logic [23:0] prod;
		logic [12:0] vbat;
		logic [31:0] elapsed;
		int          v;
		int          rise;
		if (arst_n) begin
			if (cfg_we) begin
				case (bgct_pkg::reg_idx_t'(cfg_index))
					bgct_pkg::REG_PRESENT_MIN: cfg_shadow.present_min_mv  = cfg_wdata[11:0];
					bgct_pkg::REG_DIVIDER:     cfg_shadow.divider_q8      = cfg_wdata[11:0];
					bgct_pkg::REG_WINDOW:      cfg_shadow.trend_period_ms = cfg_wdata;
					bgct_pkg::REG_RISE:        cfg_shadow.charge_rise_mv  = cfg_wdata[12:0];
					default: ;
				endcase
			end

			if (s_tvalid && s_tready) begin
				smp = bgct_pkg::in_t'(s_tdata[bgct_pkg::IN_W-1:0]);
				accepted_samples++;
				sum_raw += smp.adc_raw;
				sum_mv  += smp.adc_mv;
				fill_cnt++;
				if (fill_cnt == SAMPLES_PER_GROUP) begin
					want              = '0;
					want.usb_present  = smp.usb_sense;
					want.raw_avg      = 12'(sum_raw / SAMPLES_PER_GROUP);
					want.pin_mv_avg   = 12'(sum_mv / SAMPLES_PER_GROUP);
					want.batt_present = want.pin_mv_avg >= cfg_shadow.present_min_mv;
					sum_raw  = '0;
					sum_mv   = '0;
					fill_cnt = 0;
					if (!want.batt_present) begin
						// restart the trend from zero so the present group that closes the window evaluates a rise
						chg_latched = 1'b0;
						window_open = 1'b1;
						window_t0   = smp.now_ms;
						window_mv0  = '0;
					end else begin
						prod = want.pin_mv_avg * cfg_shadow.divider_q8;
						if (prod[23:8] < bgct_pkg::VBAT_MIN_MV)
							vbat = bgct_pkg::VBAT_MIN_MV;
						else if (prod[23:8] > bgct_pkg::VBAT_MAX_MV)
							vbat = bgct_pkg::VBAT_MAX_MV;
						else
							vbat = prod[20:8];
						want.vbat_mv = vbat;

						v = int'(vbat);
						if (v >= int'(bgct_pkg::PCT_HIGH_MV))
							want.charge_pct = bgct_pkg::PCT_FULL;
						else if (v <= int'(bgct_pkg::PCT_LOW_MV))
							want.charge_pct = '0;
						else if (v < int'(bgct_pkg::PCT_MID_MV))
							want.charge_pct = 7'((v - int'(bgct_pkg::PCT_LOW_MV))
								* int'(bgct_pkg::PCT_HALF)
								/ int'(bgct_pkg::PCT_MID_MV - bgct_pkg::PCT_LOW_MV));
						else
							want.charge_pct = 7'(int'(bgct_pkg::PCT_HALF)
								+ (v - int'(bgct_pkg::PCT_MID_MV)) * int'(bgct_pkg::PCT_HALF)
								/ int'(bgct_pkg::PCT_HIGH_MV - bgct_pkg::PCT_MID_MV));

						elapsed = smp.now_ms - window_t0;
						if (!window_open) begin
							window_open = 1'b1;
							window_t0   = smp.now_ms;
							window_mv0  = vbat;
							chg_latched = 1'b0;
						end else if (elapsed >= cfg_shadow.trend_period_ms) begin
							rise        = v - int'(window_mv0);
							chg_latched = rise >= int'(cfg_shadow.charge_rise_mv);
							window_t0   = smp.now_ms;
							window_mv0  = vbat;
						end
					end
					want.charging = chg_latched;
					expected_readings.push_back(want);
				end
			end

			if (m_tvalid && m_tready) begin
				got = bgct_pkg::result_t'(m_tdata[bgct_pkg::RES_W-1:0]);
				if (expected_readings.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: reading with none pending: vbat=%0d pct=%0d", $realtime,
							got.vbat_mv, got.charge_pct);
				end else begin
					want = expected_readings.pop_front();
					checked_readings++;
					if (!want.batt_present)
						absent_seen++;
					if (want.charging)
						charging_seen++;
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("%0t: reading %0d mismatch", $realtime, checked_readings);
							$display("  expected present=%0d usb=%0d raw=%0d mv=%0d vbat=%0d pct=%0d chg=%0d",
								want.batt_present, want.usb_present, want.raw_avg,
								want.pin_mv_avg, want.vbat_mv, want.charge_pct, want.charging);
							$display("  actual   present=%0d usb=%0d raw=%0d mv=%0d vbat=%0d pct=%0d chg=%0d",
								got.batt_present, got.usb_present, got.raw_avg,
								got.pin_mv_avg, got.vbat_mv, got.charge_pct, got.charging);
						end
					end
				end
			end
		end
	end

	task automatic push_sample(input logic [11:0] raw, input logic [11:0] mv,
		input logic usb, input logic [31:0] now);
		bgct_pkg::in_t s;
		s.adc_raw   = raw;
		s.adc_mv    = mv;
		s.usb_sense = usb;
		s.now_ms    = now;
		pending_samples.push_back(s);
	endtask

	// hold until every sample is taken and every reading has come back, then let
	// the pipeline settle before touching registers
	task automatic drain;
		while (pending_samples.size() != 0 || s_tvalid || expected_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_regs(input logic [31:0] min_mv, input logic [31:0] div,
		input logic [31:0] win, input logic [31:0] rise);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= bgct_pkg::REG_PRESENT_MIN;
		cfg_wdata <= min_mv;
		@(posedge clk);
		cfg_index <= bgct_pkg::REG_DIVIDER;
		cfg_wdata <= div;
		@(posedge clk);
		cfg_index <= bgct_pkg::REG_WINDOW;
		cfg_wdata <= win;
		@(posedge clk);
		cfg_index <= bgct_pkg::REG_RISE;
		cfg_wdata <= rise;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// groups mostly track a slowly drifting pin voltage inside the gauge range so
	// the trend sees real rises and falls; the rest are noise, absent or full scale
	task automatic run_phase(input int n_groups, input int div, input int thresh,
		input int step_max);
		int lo;
		int hi;
		int base;
		int center;
		int spread;
		int kind;
		int mv;
		lo = 0;
		hi = 4095;
		if (div >= 200) begin
			lo = 2900 * 256 / div;
			hi = 4450 * 256 / div;
			if (lo > 4095)
				lo = 4095;
			if (hi > 4095)
				hi = 4095;
		end
		base     = $urandom_range(hi, lo);
		stamp_ms = $urandom;
		for (int g = 0; g < n_groups; g++) begin
			kind   = $urandom_range(0, 19);
			spread = 6;
			if (kind < 14) begin
				base = base + int'($urandom_range(0, 40)) - 18;
				if (base < lo)
					base = lo;
				if (base > hi)
					base = hi;
				center = base;
			end else if (kind < 17) begin
				center = -1;
			end else if (kind < 19) begin
				center = $urandom_range(0, thresh > 0 ? thresh - 1 : 0);
			end else begin
				center = 4095;
				spread = 0;
			end
			for (int i = 0; i < SAMPLES_PER_GROUP; i++) begin
				if (center < 0) begin
					mv = $urandom_range(0, 4095);
				end else begin
					mv = center + int'($urandom_range(0, 2 * spread)) - spread;
					if (mv < 0)
						mv = 0;
					if (mv > 4095)
						mv = 4095;
				end
				stamp_ms += $urandom_range(0, step_max);
				push_sample(12'($urandom_range(0, 4095)), 12'(mv), 1'($urandom_range(0, 1)),
					stamp_ms);
			end
		end
		drain();
	endtask

	initial begin : stimulus
		int          r_min;
		int          r_div;
		logic [31:0] r_win;
		logic [31:0] r_rise;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full-scale group: clamps high, opens the first window
		for (int i = 0; i < SAMPLES_PER_GROUP; i++)
			push_sample(12'hFFF, 12'hFFF, 1'b1, 32'hFFFF_0000 + i);
		// all-zero group: battery absent, trend restarts at the top of the time range
		for (int i = 0; i < SAMPLES_PER_GROUP; i++)
			push_sample(12'h000, 12'h000, 1'b0, 32'hFFFF_FFF8 + i);
		// mid-scale group across the time wrap: window elapses, rise from zero flags charging
		for (int i = 0; i < SAMPLES_PER_GROUP; i++)
			push_sample(i[0] ? 12'hFFF : 12'h000, 12'd1850, i[0], 32'd59999 + i);
		drain();

		run_phase(22, 512, 500, 3000);

		// lowest settings: always present, divider zero clamps low, evaluate every group
		program_regs(32'd0, 32'd0, 32'd0, 32'd0);
		run_phase(22, 0, 0, 50);

		// highest settings: presence only at full scale, window practically never closes
		program_regs(32'd4095, 32'd4095, 32'hFFFF_FFFF, 32'd4350);
		run_phase(22, 4095, 4095, 1000);

		// junk above each register's width must be dropped
		program_regs(32'hFFFF_F4B0, 32'hFFFF_F258, 32'd1, 32'hFFFF_FFFF);
		run_phase(22, 600, 1200, 3);

		r_min  = $urandom_range(300, 1500);
		r_div  = $urandom_range(400, 800);
		r_win  = $urandom_range(1, 5000);
		r_rise = $urandom_range(0, 60);
		program_regs(r_min, r_div, r_win, r_rise);
		run_phase(22, r_div, r_min, 400);

		// closing stretch at full rate on both sides
		idling_on = 1'b0;
		program_regs(32'd800, 32'd520, 32'd200, 32'd15);
		run_phase(22, 520, 800, 60);

		$display("Covered %0d samples and %0d readings over six register settings",
			accepted_samples, checked_readings);
		$display("  %0d readings with battery absent, %0d with charging set, %0d errors",
			absent_seen, charging_seen, fail_count);
		if (fail_count == 0 && expected_readings.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/bgct_pkg.sv
rtl/bgct_accum.sv
rtl/bgct_scale.sv
rtl/bgct_trend.sv
rtl/battery_gauge_charge_trend.sv
rtl/bgct_checker.sv
dv/battery_gauge_charge_trend_tb.sv
